// File: rtl/pfq_pkg.sv
`default_nettype none
package pfq_pkg;

    localparam int TICK_W  = 15;
    localparam int US_W    = 16;
    localparam int RATE_W  = 27;
    localparam int MIN_W   = 16;
    localparam int CNT_W   = 32;
    localparam int NUM_W   = 35;
    localparam int SCALE_W = 20;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [SCALE_W-1:0] US_PER_SECOND = 20'd1000000;
    localparam logic [RATE_W-1:0]  RATE_ONE_MHZ  = 27'd1000000;
    localparam logic [US_W-1:0]    US_SATURATED  = 16'hFFFF;

    // register index, taken from paddr[2]
    localparam logic REG_TICK_RATE = 1'b0;
    localparam logic REG_MIN_COUNT = 1'b1;

    localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    typedef enum logic [1:0] {
        PHASE_COLLECTING,
        PHASE_ENDED,
        PHASE_TRUNCATED
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HALF1,
        S_CONV1,
        S_HALF2,
        S_CONV2,
        S_JUDGE,
        S_SINGLE,
        S_EMIT_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic sel_second;
        logic half_end;
        logic half_trunc;
        logic conv_start;
        logic store;
        logic judge;
        logic idx_clear;
        logic idx_inc;
        logic load_single;
        logic load_pulse;
    } pfq_cmd_t;

    typedef struct packed {
        logic collecting;
        logic ticks_zero;
        logic full;
        logic conv_done;
        logic cap_end;
        logic verdict_emit;
        logic idx_last;
        logic out_free;
    } pfq_stat_t;

endpackage
`default_nettype wire

// File: rtl/pfq_ram.sv
`default_nettype none
module pfq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/pfq_conv.sv
`default_nettype none
module pfq_conv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pfq_pkg::TICK_W-1:0]    ticks,
    input  wire logic [pfq_pkg::RATE_W-1:0]    rate,
    output logic                               done,
    output logic      [pfq_pkg::US_W-1:0]      us
);
    import pfq_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [5:0]         step_reg, step_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [RATE_W:0]    rem_reg, rem_next;
    logic [US_W-1:0]    res_reg, res_next;

    logic [RATE_W:0]    rem_shift;
    logic               fit;

    // one quotient bit a cycle: shift the numerator into the remainder
    assign rem_shift = {rem_reg[RATE_W-1:0], num_reg[NUM_W-1]};
    assign fit       = rem_shift >= {1'b0, rate};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (start)
        begin
            if (rate == RATE_ONE_MHZ)
            begin
                res_next  = US_W'(ticks);
                done_next = 1'b1;
            end
            else if (rate == '0)
            begin
                res_next  = US_SATURATED;
                done_next = 1'b1;
            end
            else
            begin
                num_next  = NUM_W'(ticks) * NUM_W'(US_PER_SECOND);
                rem_next  = '0;
                step_next = 6'(NUM_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fit ? rem_shift - {1'b0, rate} : rem_shift;
            num_next  = {num_reg[NUM_W-2:0], fit};
            step_next = step_reg - 6'd1;
            if (step_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = (num_next[NUM_W-1:US_W] != '0) ? US_SATURATED
                                                           : num_next[US_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign us   = res_reg;

endmodule
`default_nettype wire

// File: rtl/pfq_datapath.sv
`default_nettype none
module pfq_datapath #(
    parameter int MAX_PULSES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pfq_pkg::pfq_cmd_t             cmd,
    output pfq_pkg::pfq_stat_t                 stat,
    input  wire logic [pfq_pkg::RATE_W-1:0]    tick_rate_hz,
    input  wire logic [pfq_pkg::MIN_W-1:0]     min_pulse_count,
    input  wire logic                          symbol_level,
    input  wire logic [pfq_pkg::TICK_W-1:0]    ticks_first,
    input  wire logic [pfq_pkg::TICK_W-1:0]    ticks_second,
    input  wire logic                          capture_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [pfq_pkg::US_W-1:0]      pulse_us,
    output logic                               pulse_valid,
    output logic                               start_level,
    output logic      [1:0]                    frame_status,
    output logic                               last_of_frame,
    output logic      [pfq_pkg::CNT_W-1:0]     accepted_total,
    output logic      [pfq_pkg::CNT_W-1:0]     short_total,
    output logic      [pfq_pkg::CNT_W-1:0]     truncated_total
);
    import pfq_pkg::*;

    localparam int CW = $clog2(MAX_PULSES + 1);
    localparam int AW = $clog2(MAX_PULSES);

    logic [TICK_W-1:0] tf_reg, ts_reg;
    logic              end_reg;
    logic              level_reg;
    logic              at_start_reg;
    phase_t            phase_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic [1:0]        status_reg, verdict;
    logic [CNT_W-1:0]  acc_reg, short_reg, trunc_reg;

    logic              o_valid_reg;
    logic [US_W-1:0]   o_us_reg;
    logic              o_pv_reg, o_level_reg, o_last_reg;
    logic [1:0]        o_status_reg;
    logic [CNT_W-1:0]  o_acc_reg, o_short_reg, o_trunc_reg;

    logic [TICK_W-1:0] ticks_sel;
    logic              conv_done;
    logic [US_W-1:0]   conv_us;
    logic [US_W-1:0]   rd_us;
    logic              out_free;

    assign ticks_sel = cmd.sel_second ? ts_reg : tf_reg;
    assign out_free  = !o_valid_reg || out_ready;

    always_comb
    begin
        priority if (phase_reg == PHASE_TRUNCATED)
            verdict = STATUS_TRUNCATED;
        else if (MIN_W'(count_reg) < min_pulse_count)
            verdict = STATUS_SHORT;
        else
            verdict = STATUS_ACCEPTED;
    end

    assign stat.collecting   = phase_reg == PHASE_COLLECTING;
    assign stat.ticks_zero   = ticks_sel == '0;
    assign stat.full         = count_reg == CW'(MAX_PULSES);
    assign stat.conv_done    = conv_done;
    assign stat.cap_end      = end_reg;
    assign stat.verdict_emit = (verdict == STATUS_ACCEPTED) && (count_reg != '0);
    assign stat.idx_last     = idx_reg == count_reg - CW'(1);
    assign stat.out_free     = out_free;

    pfq_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.conv_start),
        .ticks (ticks_sel),
        .rate  (tick_rate_hz),
        .done  (conv_done),
        .us    (conv_us)
    );

    pfq_ram #(
        .WIDTH (US_W),
        .DEPTH (MAX_PULSES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (count_reg[AW-1:0]),
        .wdata (conv_us),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_us)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tf_reg  <= ticks_first;
            ts_reg  <= ticks_second;
            end_reg <= capture_end;
        end
        if (cmd.judge)
        begin
            status_reg <= verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= 1'b0;
            at_start_reg <= 1'b1;
            phase_reg    <= PHASE_COLLECTING;
            count_reg    <= '0;
            idx_reg      <= '0;
            acc_reg      <= '0;
            short_reg    <= '0;
            trunc_reg    <= '0;
        end
        else
        begin
            // open a new frame on its first transaction
            if (cmd.capture && at_start_reg)
            begin
                level_reg    <= symbol_level;
                at_start_reg <= 1'b0;
                count_reg    <= '0;
                phase_reg    <= PHASE_COLLECTING;
            end
            if (cmd.half_end)
            begin
                phase_reg <= PHASE_ENDED;
            end
            if (cmd.half_trunc)
            begin
                phase_reg <= PHASE_TRUNCATED;
            end
            if (cmd.store)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.judge)
            begin
                at_start_reg <= 1'b1;
                phase_reg    <= PHASE_COLLECTING;
                unique case (verdict)
                    STATUS_TRUNCATED: trunc_reg <= trunc_reg + CNT_W'(1);
                    STATUS_SHORT:     short_reg <= short_reg + CNT_W'(1);
                    default:          acc_reg   <= acc_reg + CNT_W'(1);
                endcase
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (cmd.load_single || cmd.load_pulse)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_single || cmd.load_pulse)
        begin
            o_level_reg <= level_reg;
            o_acc_reg   <= acc_reg;
            o_short_reg <= short_reg;
            o_trunc_reg <= trunc_reg;
        end
        if (cmd.load_single)
        begin
            o_us_reg     <= '0;
            o_pv_reg     <= 1'b0;
            o_status_reg <= status_reg;
            o_last_reg   <= 1'b1;
        end
        else if (cmd.load_pulse)
        begin
            o_us_reg     <= rd_us;
            o_pv_reg     <= 1'b1;
            o_status_reg <= STATUS_ACCEPTED;
            o_last_reg   <= stat.idx_last;
        end
    end

    assign out_valid       = o_valid_reg;
    assign pulse_us        = o_us_reg;
    assign pulse_valid     = o_pv_reg;
    assign start_level     = o_level_reg;
    assign frame_status    = o_status_reg;
    assign last_of_frame   = o_last_reg;
    assign accepted_total  = o_acc_reg;
    assign short_total     = o_short_reg;
    assign truncated_total = o_trunc_reg;

endmodule
`default_nettype wire

// File: rtl/pfq_ctrl.sv
`default_nettype none
module pfq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pfq_pkg::pfq_stat_t   stat,
    output pfq_pkg::pfq_cmd_t         cmd
);
    import pfq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_HALF1;
            S_HALF1:
                if (stat.collecting && !stat.ticks_zero && !stat.full)
                    state_next = S_CONV1;
                else
                    state_next = S_HALF2;
            S_CONV1:
                if (stat.conv_done)
                    state_next = S_HALF2;
            S_HALF2:
                if (stat.collecting && !stat.ticks_zero && !stat.full)
                    state_next = S_CONV2;
                else
                    state_next = stat.cap_end ? S_JUDGE : S_IDLE;
            S_CONV2:
                if (stat.conv_done)
                    state_next = stat.cap_end ? S_JUDGE : S_IDLE;
            S_JUDGE:
                state_next = stat.verdict_emit ? S_EMIT_WAIT : S_SINGLE;
            S_SINGLE:
                if (stat.out_free)
                    state_next = S_IDLE;
            S_EMIT_WAIT:
                state_next = S_EMIT;
            S_EMIT:
                if (stat.out_free)
                    state_next = stat.idx_last ? S_IDLE : S_EMIT_WAIT;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_HALF1, S_HALF2:
            begin
                cmd.sel_second = state_reg == S_HALF2;
                if (stat.collecting)
                begin
                    priority if (stat.ticks_zero)
                        cmd.half_end = 1'b1;
                    else if (stat.full)
                        cmd.half_trunc = 1'b1;
                    else
                        cmd.conv_start = 1'b1;
                end
            end
            S_CONV1, S_CONV2:
            begin
                cmd.sel_second = state_reg == S_CONV2;
                cmd.store      = stat.conv_done;
            end
            S_JUDGE:
            begin
                cmd.judge     = 1'b1;
                cmd.idx_clear = 1'b1;
            end
            S_SINGLE:
                cmd.load_single = stat.out_free;
            S_EMIT:
            begin
                cmd.load_pulse = stat.out_free;
                cmd.idx_inc    = stat.out_free && !stat.idx_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/pulse_frame_qualifier.sv
`default_nettype none
// Channel   Handshake            Payload
// config    psel/penable/pready  paddr, pwdata, prdata (0x0 tick_rate_hz, 0x4 min_pulse_count)
// symbol    in_valid/in_ready    symbol_level, ticks_first, ticks_second, capture_end
// result    out_valid/out_ready  pulse_us, pulse_valid, start_level, frame_status,
//                                last_of_frame, accepted_total, short_total, truncated_total
//
// One symbol transaction at a time. Each stored half goes through the scaling unit:
// at a 1 MHz tick rate it passes the ticks through and at a zero rate it saturates,
// otherwise it takes a multiply step, a 35-bit restoring division and a hand-over.
// A closing symbol adds a judge state, then a store read and an emit per pulse.
// The result register lets the next symbol in while the last result waits; a frame
// that must emit stalls when out_ready is low. Reset clears all control state.
module pulse_frame_qualifier #(
    parameter int MAX_PULSES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pfq_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [pfq_pkg::DATA_W-1:0]    pwdata,
    output logic      [pfq_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          symbol_level,
    input  wire logic [pfq_pkg::TICK_W-1:0]    ticks_first,
    input  wire logic [pfq_pkg::TICK_W-1:0]    ticks_second,
    input  wire logic                          capture_end,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [pfq_pkg::US_W-1:0]      pulse_us,
    output logic                               pulse_valid,
    output logic                               start_level,
    output logic      [1:0]                    frame_status,
    output logic                               last_of_frame,
    output logic      [pfq_pkg::CNT_W-1:0]     accepted_total,
    output logic      [pfq_pkg::CNT_W-1:0]     short_total,
    output logic      [pfq_pkg::CNT_W-1:0]     truncated_total
);
    import pfq_pkg::*;

    logic [RATE_W-1:0] rate_reg;
    logic [MIN_W-1:0]  min_reg;
    logic              wr_en;
    pfq_cmd_t          cmd;
    pfq_stat_t         stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_ONE_MHZ;
            min_reg  <= MIN_W'(32);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_TICK_RATE: rate_reg <= pwdata[RATE_W-1:0];
                REG_MIN_COUNT: min_reg  <= pwdata[MIN_W-1:0];
                default:       rate_reg <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TICK_RATE: prdata = DATA_W'(rate_reg);
            REG_MIN_COUNT: prdata = DATA_W'(min_reg);
            default:       prdata = '0;
        endcase
    end

    pfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfq_datapath #(
        .MAX_PULSES (MAX_PULSES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .tick_rate_hz    (rate_reg),
        .min_pulse_count (min_reg),
        .symbol_level    (symbol_level),
        .ticks_first     (ticks_first),
        .ticks_second    (ticks_second),
        .capture_end     (capture_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pulse_us        (pulse_us),
        .pulse_valid     (pulse_valid),
        .start_level     (start_level),
        .frame_status    (frame_status),
        .last_of_frame   (last_of_frame),
        .accepted_total  (accepted_total),
        .short_total     (short_total),
        .truncated_total (truncated_total)
    );

endmodule
`default_nettype wire

// File: verif/pfq_checker.sv
module pfq_checker
    import pfq_pkg::*;
#(
    parameter int MAX_PULSES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                symbol_level,
    input  logic [TICK_W-1:0]   ticks_first,
    input  logic [TICK_W-1:0]   ticks_second,
    input  logic                capture_end,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [US_W-1:0]     pulse_us,
    input  logic                pulse_valid,
    input  logic                start_level,
    input  logic [1:0]          frame_status,
    input  logic                last_of_frame,
    input  logic [CNT_W-1:0]    accepted_total,
    input  logic [CNT_W-1:0]    short_total,
    input  logic [CNT_W-1:0]    truncated_total,
    input  logic                drain_done,
    output int                  awaited_count,
    output int                  error_count
);

    typedef struct {
        logic [US_W-1:0]  us;
        logic             valid;
        logic             level;
        logic [1:0]       status;
        logic             last;
        logic [CNT_W-1:0] accepted;
        logic [CNT_W-1:0] too_short;
        logic [CNT_W-1:0] truncated;
    } frame_result_t;

    logic [RATE_W-1:0] rate_hz;
    logic [MIN_W-1:0]  min_count;
    logic [US_W-1:0]   pulse_mem [64];
    int unsigned       pulses_held;
    logic              frame_lvl;
    phase_t            phase;
    logic              at_start;
    logic [CNT_W-1:0]  n_accepted;
    logic [CNT_W-1:0]  n_short;
    logic [CNT_W-1:0]  n_truncated;
    frame_result_t     awaited_results [$];
    bit                leftover_reported;

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [US_W-1:0] scale_to_us(logic [TICK_W-1:0] ticks);
        longint unsigned num;
        longint unsigned den;
        longint unsigned us;
        num = ticks;
        den = rate_hz;
        if (rate_hz == RATE_ONE_MHZ)
            us = num;
        else if (den == 0)
            us = US_SATURATED;
        else
            us = (num * 64'd1000000) / den;
        return (us > 65535) ? US_SATURATED : us[US_W-1:0];
    endfunction

    function automatic void collect_half(logic [TICK_W-1:0] ticks);
        if (phase != PHASE_COLLECTING)
            return;
        if (ticks == '0) begin
            phase = PHASE_ENDED;
            return;
        end
        if (pulses_held >= MAX_PULSES) begin
            phase = PHASE_TRUNCATED;
            return;
        end
        pulse_mem[pulses_held] = scale_to_us(ticks);
        pulses_held++;
    endfunction

    function automatic void push_result(logic [US_W-1:0] us, logic valid, logic [1:0] status,
                                        logic last);
        frame_result_t r;
        r.us        = us;
        r.valid     = valid;
        r.level     = frame_lvl;
        r.status    = status;
        r.last      = last;
        r.accepted  = n_accepted;
        r.too_short = n_short;
        r.truncated = n_truncated;
        awaited_results.push_back(r);
    endfunction

    function automatic void judge_frame();
        if (phase == PHASE_TRUNCATED) begin
            n_truncated++;
            push_result('0, 1'b0, STATUS_TRUNCATED, 1'b1);
        end else if (pulses_held < min_count) begin
            n_short++;
            push_result('0, 1'b0, STATUS_SHORT, 1'b1);
        end else begin
            n_accepted++;
            if (pulses_held == 0)
                push_result('0, 1'b0, STATUS_ACCEPTED, 1'b1);
            else
                for (int i = 0; i < pulses_held; i++)
                    push_result(pulse_mem[i], 1'b1, STATUS_ACCEPTED, i + 1 == pulses_held);
        end
        pulses_held = 0;
        phase       = PHASE_COLLECTING;
        at_start    = 1'b1;
    endfunction

    function automatic void take_symbol();
        if (at_start) begin
            frame_lvl   = symbol_level;
            at_start    = 1'b0;
            pulses_held = 0;
            phase       = PHASE_COLLECTING;
        end
        collect_half(ticks_first);
        collect_half(ticks_second);
        if (capture_end)
            judge_frame();
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        frame_result_t want;
        if (!rst_n) begin
            rate_hz           = RATE_ONE_MHZ;
            min_count         = 16'd32;
            pulses_held       = 0;
            frame_lvl         = 1'b0;
            phase             = PHASE_COLLECTING;
            at_start          = 1'b1;
            n_accepted        = '0;
            n_short           = '0;
            n_truncated       = '0;
            leftover_reported = 1'b0;
            awaited_results.delete();
            awaited_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TICK_RATE)
                    rate_hz = pwdata[RATE_W-1:0];
                else
                    min_count = pwdata[MIN_W-1:0];
            end
            if (in_valid && in_ready)
                take_symbol();
            if (out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: pulse_us %0d status %0d",
                                              pulse_us, frame_status));
                end else begin
                    want = awaited_results.pop_front();
                    if (pulse_us !== want.us)
                        report_mismatch($sformatf("pulse_us got %0d expected %0d",
                                                  pulse_us, want.us));
                    if (pulse_valid !== want.valid)
                        report_mismatch($sformatf("pulse_valid got %0b expected %0b",
                                                  pulse_valid, want.valid));
                    if (start_level !== want.level)
                        report_mismatch($sformatf("start_level got %0b expected %0b",
                                                  start_level, want.level));
                    if (frame_status !== want.status)
                        report_mismatch($sformatf("frame_status got %0d expected %0d",
                                                  frame_status, want.status));
                    if (last_of_frame !== want.last)
                        report_mismatch($sformatf("last_of_frame got %0b expected %0b",
                                                  last_of_frame, want.last));
                    if (accepted_total !== want.accepted)
                        report_mismatch($sformatf("accepted_total got %0d expected %0d",
                                                  accepted_total, want.accepted));
                    if (short_total !== want.too_short)
                        report_mismatch($sformatf("short_total got %0d expected %0d",
                                                  short_total, want.too_short));
                    if (truncated_total !== want.truncated)
                        report_mismatch($sformatf("truncated_total got %0d expected %0d",
                                                  truncated_total, want.truncated));
                end
            end
            if (drain_done && !leftover_reported && awaited_results.size() != 0) begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          awaited_results.size()));
                leftover_reported = 1'b1;
            end
            awaited_count <= awaited_results.size();
        end
    end

endmodule

// File: verif/testbench.sv
module testbench;
    import pfq_pkg::*;

    localparam int MAX_PULSES     = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 100;
    localparam int END_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [ADDR_W-1:0] ADDR_TICK_RATE = 3'h0;
    localparam logic [ADDR_W-1:0] ADDR_MIN_COUNT = 3'h4;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic                symbol_level;
    logic [TICK_W-1:0]   ticks_first;
    logic [TICK_W-1:0]   ticks_second;
    logic                capture_end;
    logic                out_valid;
    logic                out_ready;
    logic [US_W-1:0]     pulse_us;
    logic                pulse_valid;
    logic                start_level;
    logic [1:0]          frame_status;
    logic                last_of_frame;
    logic [CNT_W-1:0]    accepted_total;
    logic [CNT_W-1:0]    short_total;
    logic [CNT_W-1:0]    truncated_total;
    logic                drain_done;
    int                  awaited_count;
    int                  error_count;

    logic                hold_token;
    int                  symbols_sent;
    int                  burst_left;

    pulse_frame_qualifier #(.MAX_PULSES(MAX_PULSES)) DUT (.*);

    pfq_checker #(.MAX_PULSES(MAX_PULSES)) pulse_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_symbol(logic lvl, logic [TICK_W-1:0] t1, logic [TICK_W-1:0] t2,
                               logic fin);
        in_valid     <= 1'b1;
        symbol_level <= lvl;
        ticks_first  <= t1;
        ticks_second <= t2;
        capture_end  <= fin;
        do @(posedge clk); while (!in_ready);
        symbols_sent++;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    // hold the sender until every awaited result is out, then let the block settle
    task automatic quiesce(int tail);
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_count != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic set_config(logic [RATE_W-1:0] rate, logic [MIN_W-1:0] min_cnt);
        quiesce(SETTLE_CYCLES);
        apb_write(ADDR_TICK_RATE, DATA_W'(rate));
        apb_write(ADDR_MIN_COUNT, DATA_W'(min_cnt));
    endtask

    function automatic logic [TICK_W-1:0] rand_ticks();
        case ($urandom_range(0, 5))
            0:       return 15'h7FFF;
            1:       return 15'h0001;
            2:       return TICK_W'($urandom_range(1, 200));
            default: return TICK_W'($urandom_range(1, 32767));
        endcase
    endfunction

    // end marker goes on half number zero_at of the frame; negative means none
    task automatic send_frame(int nsym, int zero_at);
        logic [TICK_W-1:0] t1;
        logic [TICK_W-1:0] t2;
        for (int s = 0; s < nsym; s++) begin
            t1 = rand_ticks();
            t2 = rand_ticks();
            if (zero_at == 2 * s)
                t1 = '0;
            if (zero_at == 2 * s + 1)
                t2 = '0;
            send_symbol(1'($urandom_range(0, 1)), t1, t2, s == nsym - 1);
        end
    endtask

    task automatic random_frames(int budget);
        int first;
        int n;
        first = symbols_sent;
        while (symbols_sent - first < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_frame($urandom_range(1, 6), -1);
                6, 7:
                begin
                    n = $urandom_range(1, 5);
                    send_frame(n, $urandom_range(0, 2 * n - 1));
                end
                default: send_symbol(1'($urandom_range(0, 1)),
                                     TICK_W'($urandom_range(0, 32767)),
                                     TICK_W'($urandom_range(0, 32767)),
                                     1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // receiver: stall pattern that changes mode every so often, plus one long hold-off
    initial
    begin : receiver
        logic hold_taken;
        int   mode;
        int   mode_left;
        hold_taken = 1'b0;
        mode       = 0;
        mode_left  = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_token != hold_taken) begin
                hold_taken = hold_token;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [RATE_W-1:0] rate;
        logic [MIN_W-1:0]  min_cnt;
        symbols_sent = 0;
        burst_left   = 0;
        rate         = '0;
        min_cnt      = '0;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        symbol_level <= 1'b0;
        ticks_first  <= '0;
        ticks_second <= '0;
        capture_end  <= 1'b0;
        drain_done   <= 1'b0;
        hold_token   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pass-through extremes, end markers, empty accepted frame
        set_config(27'd1000000, 16'd0);
        send_symbol(1'b1, 15'h7FFF, 15'h0001, 1'b1);
        send_symbol(1'b1, 15'h0000, 15'h1234, 1'b1);
        send_symbol(1'b0, 15'd5, 15'h0000, 1'b0);
        send_symbol(1'b1, 15'd100, 15'd200, 1'b1);
        send_symbol(1'b0, 15'h5555, 15'h2AAA, 1'b0);
        send_symbol(1'b1, 15'h0000, 15'h0000, 1'b1);
        set_config(27'd1000000, 16'd3);
        send_symbol(1'b1, 15'd7, 15'd9, 1'b1);
        send_symbol(1'b0, 15'd1, 15'd2, 1'b0);
        send_symbol(1'b1, 15'd3, 15'd4, 1'b1);
        // zero rate saturates everything
        set_config(27'd0, 16'd1);
        send_symbol(1'b1, 15'd1, 15'h7FFF, 1'b0);
        send_symbol(1'b0, 15'd2, 15'd3, 1'b1);
        set_config(27'd1, 16'd1);
        send_symbol(1'b0, 15'd1, 15'h7FFF, 1'b1);
        set_config(27'd80000000, 16'd1);
        send_symbol(1'b1, 15'h7FFF, 15'd80, 1'b1);
        set_config(27'd80000000, 16'hFFFF);
        send_symbol(1'b1, 15'h7FFF, 15'h7FFF, 1'b1);

        // full store with the receiver held off, so emission backs up into the input
        set_config(27'd1000000, 16'd64);
        hold_token <= 1'b1;
        send_frame(33, 64);
        send_frame(34, 67);
        random_frames(4);

        for (int p = 1; p <= 7; p++) begin
            case (p)
                1:       begin rate = 27'd1;         min_cnt = 16'd0;     end
                2:       begin rate = 27'd80000000;  min_cnt = 16'd2;     end
                3:       begin rate = 27'd0;         min_cnt = 16'd1;     end
                4:       begin rate = 27'h7FFFFFF;   min_cnt = 16'hFFFF;  end
                5:       begin rate = 27'd32768;     min_cnt = 16'd3;     end
                6:       begin rate = 27'd1000000;   min_cnt = 16'd0;     end
                default:
                begin
                    rate    = RATE_W'($urandom_range(1, 80000000));
                    min_cnt = MIN_W'($urandom_range(0, 6));
                end
            endcase
            set_config(rate, min_cnt);
            random_frames(20);
        end

        quiesce(END_CYCLES);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: pulse_frame_qualifier.f
rtl/pfq_pkg.sv
rtl/pfq_ram.sv
rtl/pfq_conv.sv
rtl/pfq_datapath.sv
rtl/pfq_ctrl.sv
rtl/pulse_frame_qualifier.sv
verif/pfq_checker.sv
verif/testbench.sv
